>>> hw/rtl/lru_recency_list_core_assert.svh
// ----------------------------------------------------------------------------
// LRU recency list assertion macros
// Concurrent assertion helpers clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef LRU_RECENCY_LIST_CORE_ASSERT_SVH
`define LRU_RECENCY_LIST_CORE_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication.
`define LRL_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lru recency list: assertion failed");
// Next-cycle implication.
`define LRL_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lru recency list: assertion failed");
`else
`define LRL_ASSERT_IMP(lbl, ante, cons)
`define LRL_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> hw/rtl/lrl_pkg.sv
// ----------------------------------------------------------------------------
// LRU recency list package
// Shared types and constants of the recency list cells and top level.
// ----------------------------------------------------------------------------
package lrl_pkg;

	localparam int unsigned SLOT_W  = 4;
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned CFG_W   = 5;

	// Ring size after reset, before it is limited to the number of cells.
	localparam int unsigned RESET_ENTRIES = 16;

	// Value of every slot after reset or a rebuild.
	localparam logic [VALUE_W-1:0] VALUE_RESET = '1;

	typedef enum logic {
		OP_TOUCH  = 1'b0,
		OP_INSERT = 1'b1
	} op_t;

	// Command broadcast to every cell of the chain.
	typedef struct packed {
		logic               rebuild;
		logic               move;
		op_t                op;
		logic [SLOT_W-1:0]  slot;
		logic [VALUE_W-1:0] value;
	} cmd_t;

endpackage

>>> hw/rtl/lrl_cell.sv
// ----------------------------------------------------------------------------
// LRU recency list cell
// One position of the recency order: holds a slot number and its value, and
// takes its neighbour's entry when the list shifts behind a moved entry.
// ----------------------------------------------------------------------------
module lrl_cell #(
	parameter int unsigned IDX = 0,
	parameter int unsigned IW  = 4,
	parameter int unsigned CW  = 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lrl_pkg::cmd_t                 cmd,
	input  logic [CW-1:0]                 count,
	// entry of the cell one place nearer the head
	input  logic [IW-1:0]                 prev_id,
	input  logic [lrl_pkg::VALUE_W-1:0]   prev_val,
	// target search chain
	input  logic                          t_found_in,
	input  logic [IW-1:0]                 t_id_in,
	input  logic [lrl_pkg::VALUE_W-1:0]   t_val_in,
	output logic                          t_found_out,
	output logic [IW-1:0]                 t_id_out,
	output logic [lrl_pkg::VALUE_W-1:0]   t_val_out,
	// query search chain
	input  logic [lrl_pkg::VALUE_W-1:0]   q_val_in,
	output logic [lrl_pkg::VALUE_W-1:0]   q_val_out,
	// selected target, used by the head cell
	input  logic [IW-1:0]                 tgt_id,
	input  logic [lrl_pkg::VALUE_W-1:0]   tgt_val,
	output logic                          hit,
	output logic [IW-1:0]                 id,
	output logic [lrl_pkg::VALUE_W-1:0]   val,
	output logic [IW-1:0]                 nxt_id,
	output logic [lrl_pkg::VALUE_W-1:0]   nxt_val
);

	localparam int unsigned SW = (IW > lrl_pkg::SLOT_W) ? IW : lrl_pkg::SLOT_W;

	logic [IW-1:0]               id_q;
	logic [lrl_pkg::VALUE_W-1:0] val_q;
	logic                        in_range;
	logic                        q_hit;

	assign in_range = CW'(IDX) < count;
	assign q_hit    = in_range && (SW'(id_q) == SW'(cmd.slot));
	assign hit      = in_range && ((cmd.op == lrl_pkg::OP_INSERT) ?
		(CW'(IDX) == count - CW'(1)) : q_hit);

	// The first hit along the chain wins; there is only ever one.
	assign t_found_out = t_found_in | hit;
	assign t_id_out    = (!t_found_in && hit) ? id_q : t_id_in;
	assign t_val_out   = (!t_found_in && hit) ? val_q : t_val_in;
	assign q_val_out   = q_hit ? val_q : q_val_in;

	always_comb begin
		nxt_id  = id_q;
		nxt_val = val_q;
		if (cmd.rebuild) begin
			nxt_id  = IW'(IDX);
			nxt_val = lrl_pkg::VALUE_RESET;
		end else if (cmd.move) begin
			if (IDX == 0) begin
				nxt_id  = tgt_id;
				nxt_val = (cmd.op == lrl_pkg::OP_INSERT) ? cmd.value : tgt_val;
			end else if (!t_found_in) begin
				// The moved entry sits here or further back: shift one place.
				nxt_id  = prev_id;
				nxt_val = prev_val;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_q  <= IW'(IDX);
			val_q <= lrl_pkg::VALUE_RESET;
		end else begin
			id_q  <= nxt_id;
			val_q <= nxt_val;
		end
	end

	assign id  = id_q;
	assign val = val_q;

endmodule

>>> hw/rtl/lru_recency_list_core.sv
// ----------------------------------------------------------------------------
// LRU recency list core
// Keeps MAX_ENTRIES slots in recency order with a 32-bit value per slot.
//
// Input transfers arrive on s_tvalid/s_tready: s_tuser is the operation
// (touch or insert), s_tdata carries the slot and the insert value. Each
// input transfer gives exactly one output transfer on m_tvalid/m_tready with
// the new head slot and value, the new tail slot, the evicted value, the
// queried slot's value and, in m_tuser, the ignored flag.
// The order is held in a row of cells, head at cell 0. An insert, or a touch
// of an in-range slot, moves one entry to cell 0 while every cell in front of it
// takes its neighbour's entry, so the whole update completes in the accepting cycle.
// The result is held in an output register, valid in the cycle after the
// input transfer; one item per cycle is sustained. While the receiver stalls
// with a result pending, s_tready is low.
// Reset builds the ring of min(16, MAX_ENTRIES) slots in slot order with all
// values at -1; a write on cfg_we rebuilds it the same way with the written
// count (zero acts as one). Write the count only while the block is idle.
// ----------------------------------------------------------------------------
module lru_recency_list_core #(
	parameter int unsigned MAX_ENTRIES = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [lrl_pkg::CFG_W-1:0]    cfg_wdata,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [39:0]                  s_tdata,  // slot[3:0], value[35:4], zero[39:36]
	input  logic                         s_tuser,  // operation
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// head_slot[3:0], head_value[35:4], tail_slot[39:36], evicted_value[71:40],
	// queried_value[103:72]
	output logic [103:0]                 m_tdata,
	output logic                         m_tuser   // ignored
);

	localparam int unsigned IW = $clog2(MAX_ENTRIES);
	localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
	localparam int unsigned SW = (IW > lrl_pkg::SLOT_W) ? IW : lrl_pkg::SLOT_W;
	localparam int unsigned KW = (CW > lrl_pkg::SLOT_W) ? CW : lrl_pkg::SLOT_W;
	localparam int unsigned RST_COUNT =
		(MAX_ENTRIES < lrl_pkg::RESET_ENTRIES) ? MAX_ENTRIES : lrl_pkg::RESET_ENTRIES;
	localparam int unsigned VW = lrl_pkg::VALUE_W;

	// Input fields.
	logic [lrl_pkg::SLOT_W-1:0] in_slot;
	logic [VW-1:0]              in_value;
	lrl_pkg::op_t               in_op;
	logic                       accept;
	logic                       in_ign;

	// Ring size.
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;

	lrl_pkg::cmd_t cmd;

	// Chain signals, one per cell.
	logic [MAX_ENTRIES-1:0] hit_vec;
	logic [MAX_ENTRIES-1:0] t_found;
	logic [IW-1:0]          t_id    [MAX_ENTRIES];
	logic [VW-1:0]          t_val   [MAX_ENTRIES];
	logic [VW-1:0]          q_val   [MAX_ENTRIES];
	logic [IW-1:0]          cell_id [MAX_ENTRIES];
	logic [VW-1:0]          cell_val[MAX_ENTRIES];
	logic [IW-1:0]          nxt_id  [MAX_ENTRIES];
	logic [VW-1:0]          nxt_val [MAX_ENTRIES];

	logic [IW-1:0] tgt_id;
	logic [VW-1:0] tgt_val;
	logic [IW-1:0] tail_idx;
	logic [VW-1:0] queried;

	// Output register.
	logic                       out_valid_q;
	logic [lrl_pkg::SLOT_W-1:0] head_slot_q;
	logic [VW-1:0]              head_value_q;
	logic [lrl_pkg::SLOT_W-1:0] tail_slot_q;
	logic [VW-1:0]              evicted_q;
	logic [VW-1:0]              queried_q;
	logic                       ignored_q;

	assign in_slot  = s_tdata[3:0];
	assign in_value = s_tdata[35:4];
	assign in_op    = lrl_pkg::op_t'(s_tuser);

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	// The slot and the count are compared at the wider of their two widths.
	assign in_ign   = KW'(in_slot) >= KW'(count_q);

	// Clamp the written count into one to MAX_ENTRIES.
	always_comb begin
		count_d = CW'(cfg_wdata);
		if (cfg_wdata == '0) begin
			count_d = CW'(1);
		end else if (int'(cfg_wdata) > int'(MAX_ENTRIES)) begin
			count_d = CW'(MAX_ENTRIES);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CW'(RST_COUNT);
		end else if (cfg_we) begin
			count_q <= count_d;
		end
	end

	// An insert always moves the tail and a touch only an in-range slot, unless cfg_we rebuilds the ring.
	assign cmd.rebuild = cfg_we;
	assign cmd.move    = accept && !cfg_we &&
		((in_op == lrl_pkg::OP_INSERT) || !in_ign);
	assign cmd.op      = in_op;
	assign cmd.slot    = in_slot;
	assign cmd.value   = in_value;

	assign tgt_id  = t_id[MAX_ENTRIES-1];
	assign tgt_val = t_val[MAX_ENTRIES-1];

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		logic          fi;
		logic [IW-1:0] idi;
		logic [VW-1:0] vi;
		logic [VW-1:0] qi;
		logic [IW-1:0] pid;
		logic [VW-1:0] pval;

		if (i == 0) begin : g_first
			assign fi   = 1'b0;
			assign idi  = '0;
			assign vi   = '0;
			assign qi   = '0;
			assign pid  = '0;
			assign pval = '0;
		end else begin : g_rest
			assign fi   = t_found[i-1];
			assign idi  = t_id[i-1];
			assign vi   = t_val[i-1];
			assign qi   = q_val[i-1];
			assign pid  = cell_id[i-1];
			assign pval = cell_val[i-1];
		end

		lrl_cell #(
			.IDX(i),
			.IW (IW),
			.CW (CW)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.count      (count_q),
			.prev_id    (pid),
			.prev_val   (pval),
			.t_found_in (fi),
			.t_id_in    (idi),
			.t_val_in   (vi),
			.t_found_out(t_found[i]),
			.t_id_out   (t_id[i]),
			.t_val_out  (t_val[i]),
			.q_val_in   (qi),
			.q_val_out  (q_val[i]),
			.tgt_id     (tgt_id),
			.tgt_val    (tgt_val),
			.hit        (hit_vec[i]),
			.id         (cell_id[i]),
			.val        (cell_val[i]),
			.nxt_id     (nxt_id[i]),
			.nxt_val    (nxt_val[i])
		);
	end

	// The tail is the last live cell of the updated order.
	assign tail_idx = IW'(count_q - CW'(1));

	// An insert into the queried slot shows the new value; otherwise values
	// are unchanged by the operation.
	always_comb begin
		queried = q_val[MAX_ENTRIES-1];
		if (in_ign) begin
			queried = '0;
		end else if (in_op == lrl_pkg::OP_INSERT && SW'(tgt_id) == SW'(in_slot)) begin
			queried = in_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			head_slot_q  <= lrl_pkg::SLOT_W'(nxt_id[0]);
			head_value_q <= nxt_val[0];
			tail_slot_q  <= lrl_pkg::SLOT_W'(nxt_id[tail_idx]);
			evicted_q    <= (in_op == lrl_pkg::OP_INSERT) ? tgt_val : '0;
			queried_q    <= queried;
			ignored_q    <= in_ign;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {queried_q, evicted_q, tail_slot_q, head_value_q, head_slot_q};
	assign m_tuser  = ignored_q;

	`include "lru_recency_list_core_assert.svh"

	// Exactly one cell is the moved entry whenever the order changes.
	`LRL_ASSERT_IMP(a_move_onehot, cmd.move, $onehot(hit_vec))
	// The live count never leaves its legal range.
	`LRL_ASSERT_IMP(a_count_range, 1'b1, count_q >= CW'(1) && count_q <= CW'(MAX_ENTRIES))
	// An ignored slot never reports a value.
	`LRL_ASSERT_IMP(a_ign_zero, out_valid_q && ignored_q, queried_q == '0)
	// A touch never evicts.
	`LRL_ASSERT_NXT(a_touch_no_evict, accept && in_op == lrl_pkg::OP_TOUCH, evicted_q == '0)
	// A touched in-range slot becomes the head.
	`LRL_ASSERT_NXT(a_touch_head, accept && !cfg_we && in_op == lrl_pkg::OP_TOUCH && !in_ign,
		head_slot_q == $past(in_slot))

endmodule

>>> verif/lru_recency_list_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LRU recency list checker
// Watches the configuration port and both stream channels of the recency list
// core, keeps its own copy of the ring and compares every result transfer,
// field by field, with the oldest predicted result.
// ----------------------------------------------------------------------------
module lru_recency_list_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [lrl_pkg::CFG_W-1:0] cfg_wdata,
	input  logic                      s_tvalid,
	input  logic                      s_tready,
	input  logic [39:0]               s_tdata,
	input  logic                      s_tuser,
	input  logic                      m_tvalid,
	input  logic                      m_tready,
	input  logic [103:0]              m_tdata,
	input  logic                      m_tuser,
	output int unsigned               outstanding,
	output int unsigned               fail_count
);

	import lrl_pkg::*;

	localparam int unsigned SLOTS = 16;

	typedef logic [SLOT_W-1:0]  slot_t;
	typedef logic [VALUE_W-1:0] value_t;

	typedef struct packed {
		slot_t  head_slot;
		value_t head_value;
		slot_t  tail_slot;
		value_t evicted_value;
		value_t queried_value;
		logic   ignored;
	} access_result_t;

	// Shadow copy of the ring.
	slot_t       next_slot [SLOTS];
	slot_t       prev_slot [SLOTS];
	value_t      slot_value [SLOTS];
	slot_t       head_ptr;
	slot_t       tail_ptr;
	int unsigned ring_size;

	access_result_t awaited_results[$];
	int unsigned    mismatches;

	assign fail_count = mismatches;

	function void rebuild_ring(int unsigned requested);
		int unsigned n;
		n = requested;
		if (n < 1) n = 1;
		if (n > SLOTS) n = SLOTS;
		ring_size = n;
		for (int s = 0; s < SLOTS; s++) begin
			next_slot[s]  = '0;
			prev_slot[s]  = '0;
			slot_value[s] = VALUE_RESET;
		end
		for (int s = 0; s < n; s++) begin
			next_slot[s] = (s + 1 < n) ? slot_t'(s + 1) : '0;
			prev_slot[s] = (s == 0) ? slot_t'(n - 1) : slot_t'(s - 1);
		end
		head_ptr = '0;
		tail_ptr = slot_t'(n - 1);
	endfunction

	function void promote_slot(slot_t s);
		slot_t n;
		slot_t p;
		if (s == head_ptr) return;
		if (s == tail_ptr) begin
			// Only the ring rotates.
			head_ptr = s;
			tail_ptr = prev_slot[s];
			return;
		end
		n = next_slot[s];
		p = prev_slot[s];
		next_slot[p] = n;
		prev_slot[n] = p;
		next_slot[s] = head_ptr;
		prev_slot[s] = tail_ptr;
		prev_slot[head_ptr] = s;
		next_slot[tail_ptr] = s;
		head_ptr = s;
	endfunction

	function access_result_t apply_access(op_t op, slot_t s, value_t v);
		access_result_t r;
		slot_t          t;
		logic           out_of_ring;
		out_of_ring = (s >= ring_size);
		r.evicted_value = '0;
		if (op == OP_INSERT) begin
			t = tail_ptr;
			r.evicted_value = slot_value[t];
			slot_value[t] = v;
			head_ptr = t;
			tail_ptr = prev_slot[t];
		end else if (!out_of_ring) begin
			promote_slot(s);
		end
		r.head_slot     = head_ptr;
		r.head_value    = slot_value[head_ptr];
		r.tail_slot     = tail_ptr;
		r.queried_value = out_of_ring ? '0 : slot_value[s];
		r.ignored       = out_of_ring;
		return r;
	endfunction

	function void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		access_result_t want;
		if (!arst_n) begin
			rebuild_ring(RESET_ENTRIES);
			awaited_results.delete();
			outstanding <= 0;
		end else begin
			// A result can never leave on the edge that accepted its input, so the
			// compare may safely come before the prediction.
			if (m_tvalid && m_tready) begin
				if (awaited_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result transfer with none awaited, data %h",
							$realtime, m_tdata);
				end else begin
					want = awaited_results.pop_front();
					compare_field("head_slot",     want.head_slot,     m_tdata[3:0]);
					compare_field("head_value",    want.head_value,    m_tdata[35:4]);
					compare_field("tail_slot",     want.tail_slot,     m_tdata[39:36]);
					compare_field("evicted_value", want.evicted_value, m_tdata[71:40]);
					compare_field("queried_value", want.queried_value, m_tdata[103:72]);
					compare_field("ignored",       want.ignored,       m_tuser);
				end
			end
			if (cfg_we)
				rebuild_ring(cfg_wdata);
			if (s_tvalid && s_tready)
				awaited_results.push_back(apply_access(op_t'(s_tuser), s_tdata[3:0],
					s_tdata[35:4]));
			outstanding <= awaited_results.size();
		end
	end

endmodule

>>> verif/tb_lru_recency_list_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LRU recency list core testbench
// Drives touch and insert transfers into the core under a range of ring sizes
// and idle patterns on both channels; a separate checker predicts and compares
// every result, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_lru_recency_list_core;

	import lrl_pkg::*;

	// Cycles without any transfer before the run is declared hung. The slowest
	// correct stretch is a long receiver hold-off or a run of sender gaps, both
	// far shorter than this.
	localparam int unsigned QUIET_LIMIT = 4000;
	localparam int unsigned PHASE_ITEMS = 135;
	localparam int unsigned PHASES      = 8;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                cfg_we    = 1'b0;
	logic [CFG_W-1:0]    cfg_wdata = '0;
	logic                s_tvalid  = 1'b0;
	logic                s_tready;
	logic [39:0]         s_tdata   = '0;  // slot[3:0], value[35:4], zero[39:36]
	logic                s_tuser   = 1'b0; // operation
	logic                m_tvalid;
	logic                m_tready  = 1'b0;
	logic [103:0]        m_tdata;          // head_slot, head_value, tail_slot, evicted, queried
	logic                m_tuser;          // ignored

	int unsigned outstanding;
	int unsigned fail_count;

	// Idle percentages for the sender and the receiver in the current phase.
	int unsigned tx_idle_pct = 0;
	int unsigned rx_stall_pct = 0;
	// Remaining cycles of a forced receiver hold-off.
	int unsigned rx_hold_cycles = 0;
	// Ring size as the block sees it, so that most slots land inside the ring.
	int unsigned live_slots = 16;
	int unsigned quiet_cycles = 0;

	always #5 clk = ~clk;

	lru_recency_list_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	lru_recency_list_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.outstanding (outstanding),
		.fail_count  (fail_count)
	);

	// Receiver: a forced hold-off takes priority and is counted down here, so
	// that the sender keeps offering while the output register stays full and
	// the block has to drop s_tready. Otherwise it stalls at random.
	always @(posedge clk) begin
		if (rx_hold_cycles > 0) begin
			m_tready <= 1'b0;
			rx_hold_cycles--;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// Watchdog: any transfer on either channel counts as progress.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb_lru_recency_list_core failed");
				$finish;
			end
		end
	end

	// Offers one operation, possibly after a few idle cycles, and returns on
	// the edge at which the transfer is accepted. Valid is only lowered in an
	// idle cycle, so it never gets two assignments in one time step.
	task automatic offer_access(op_t op, logic [SLOT_W-1:0] slot, logic [VALUE_W-1:0] value);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata  <= {4'b0, $urandom(), 4'($urandom_range(15))};
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {4'b0, value, slot};
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	// Waits until every result has come back, then lets the output register
	// settle before returning.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Rebuilds the ring with a new size. Only called while the block is idle.
	task automatic set_ring_size(logic [CFG_W-1:0] count);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= count;
		@(posedge clk);
		cfg_we    <= 1'b0;
		if (count == 0)
			live_slots = 1;
		else if (count > 16)
			live_slots = 16;
		else
			live_slots = count;
	endtask

	// A random operation: mostly slots inside the ring, some beyond it, and
	// values that now and then sit at the extremes of the signed and unsigned ranges.
	task automatic offer_random_access();
		logic [SLOT_W-1:0]  slot;
		logic [VALUE_W-1:0] value;
		op_t                op;
		op = op_t'($urandom_range(1));
		if ($urandom_range(99) < 85)
			slot = SLOT_W'($urandom_range(live_slots - 1));
		else
			slot = SLOT_W'($urandom_range(15));
		case ($urandom_range(19))
			0: value = 32'h0000_0000;
			1: value = 32'hFFFF_FFFF;
			2: value = 32'h7FFF_FFFF;
			3: value = 32'h8000_0000;
			default: value = $urandom();
		endcase
		offer_access(op, slot, value);
	endtask

	initial begin
		logic [CFG_W-1:0] phase_sizes [PHASES];
		phase_sizes = '{5'd16, 5'd2, 5'd31, 5'd5, 5'd3, 5'd16, 5'd1, 5'd9};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Full ring of sixteen from reset: touching the head changes nothing,
		// touching the tail only rotates, a middle slot is unlinked and moved.
		offer_access(OP_TOUCH, 4'd0, '0);
		offer_access(OP_TOUCH, 4'd15, '0);
		offer_access(OP_TOUCH, 4'd7, '0);
		// Inserts at the extremes of the value range, each evicting the tail.
		offer_access(OP_INSERT, 4'd0, 32'h7FFF_FFFF);
		offer_access(OP_INSERT, 4'd14, 32'h8000_0000);
		offer_access(OP_INSERT, 4'd7, 32'h0000_0000);
		offer_access(OP_INSERT, 4'd3, 32'hFFFF_FFFF);
		offer_access(OP_TOUCH, 4'd14, '0);
		offer_access(OP_TOUCH, 4'd1, '0);
		offer_access(OP_TOUCH, 4'd13, '0);

		// Ring of four: slots beyond it are ignored by a touch, while an insert
		// still goes ahead and only flags the query.
		set_ring_size(5'd4);
		offer_access(OP_TOUCH, 4'd9, '0);
		offer_access(OP_INSERT, 4'd15, 32'h1234_5678);
		offer_access(OP_TOUCH, 4'd3, '0);
		offer_access(OP_TOUCH, 4'd1, '0);
		offer_access(OP_TOUCH, 4'd0, '0);

		// A single slot is head and tail at once.
		set_ring_size(5'd1);
		offer_access(OP_TOUCH, 4'd0, '0);
		offer_access(OP_INSERT, 4'd0, 32'hA5A5_A5A5);
		offer_access(OP_TOUCH, 4'd5, '0);
		offer_access(OP_INSERT, 4'd1, 32'h5A5A_5A5A);

		// A size of zero must act as one.
		set_ring_size(5'd0);
		offer_access(OP_INSERT, 4'd0, 32'h0000_0001);
		offer_access(OP_TOUCH, 4'd0, '0);
		offer_access(OP_TOUCH, 4'd15, '0);

		// Random phases, cycling through the idle patterns: none, sender idle,
		// receiver stalling, and both at a lower rate.
		for (int p = 0; p < PHASES; p++) begin
			set_ring_size(phase_sizes[p]);
			case (p % 4)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 60; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 60; end
				default: begin tx_idle_pct = 15; rx_stall_pct = 15; end
			endcase
			// In the first phase the receiver holds off for a long stretch while
			// the sender offers back to back, so the block fills and stalls.
			if (p == 0)
				rx_hold_cycles = 80;
			for (int i = 0; i < PHASE_ITEMS; i++)
				offer_random_access();
		end

		drain_results();
		if (fail_count == 0 && outstanding == 0)
			$display("tb_lru_recency_list_core passed");
		else
			$display("tb_lru_recency_list_core failed");
		$finish;
	end

endmodule
